// File: rtl/wpl_pkg.sv
`timescale 1ns / 1ps
package wpl_pkg;

  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned VALUE_W     = 10;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned TOTAL_W     = 20;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned ENTRIES_W   = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_RESTART = 3'd2,
    OP_UNIFORM = 3'd3,
    OP_DRAW    = 3'd4
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_DEFAULT = 2'd1,
    ST_NONE    = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // one table entry as stored in either RAM
  typedef struct packed {
    logic [LIMIT_W-1:0]  uses;
    logic [WEIGHT_W-1:0] weight;
    logic [VALUE_W-1:0]  value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/wpl_ram.sv
`timescale 1ns / 1ps
module wpl_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/weighted_pick_with_use_limits_unit.sv
`timescale 1ns / 1ps
// Weighted pick with use limits. Requests carry an op in in_tuser: clear the
// master table, append an entry, restart (copy master into the working table
// and sum weights), uniform restart (weights 1, no limits) or draw (walk the
// cumulative working weights with in_tdata.draw). Every request returns one
// result with status in out_tuser. Both tables sit in single-port-read RAMs
// with a registered read, so each walk step reads an entry in one state and
// uses it in the next: restart copies each master entry, a draw scans up to
// the pick, and a limited entry that runs out of uses is removed by closing
// up the entries after it. A new request is taken as soon as the previous
// result sits in the output register. Reset needs no clearing pass.
module weighted_pick_with_use_limits_unit
  import wpl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // entry_value[9:0], entry_weight[25:10],
                                 // entry_limit[33:26], draw[53:34], zero fill
  input  logic [2:0]  in_tuser,  // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // chosen_value[9:0], remaining_total[29:10],
                                 // remaining_entries[34:30], zero fill
  output logic [1:0]  out_tuser  // status[1:0]
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RS_RD = 8'b0000_0010,  // restart: read master entry
    S_RS_WR = 8'b0000_0100,  // restart: write working entry, add weight
    S_DR_RD = 8'b0000_1000,  // draw: read working entry
    S_DR_CM = 8'b0001_0000,  // draw: compare and pick
    S_SH_RD = 8'b0010_0000,  // close up: read next entry
    S_SH_WR = 8'b0100_0000,  // close up: write it one place down
    S_FIN   = 8'b1000_0000   // hand result to output register
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     mcount_r, mcount_nxt;
  logic [CW-1:0]     wcount_r, wcount_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [TOTAL_W-1:0] pick_r, pick_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  op_t               op_r, op_nxt;
  status_t           status_r, status_nxt;
  logic [VALUE_W-1:0] chosen_r, chosen_nxt;

  logic              out_valid_r;
  logic [39:0]       out_data_r;
  status_t           out_status_r;

  // unpacked request fields
  logic [VALUE_W-1:0]  in_value;
  logic [WEIGHT_W-1:0] in_weight;
  logic [LIMIT_W-1:0]  in_limit;
  logic [TOTAL_W-1:0]  in_draw;
  assign in_value  = in_tdata[9:0];
  assign in_weight = in_tdata[25:10];
  assign in_limit  = in_tdata[33:26];
  assign in_draw   = in_tdata[53:34];

  // RAM ports
  logic          m_we, w_we;
  logic [AW-1:0] m_waddr, m_raddr, w_waddr, w_raddr;
  entry_t        m_wdata, m_rdata, w_wdata, w_rdata;

  wpl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_master_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  wpl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_work_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  logic [CW-1:0]       idx_inc;
  logic [TOTAL_W:0]    sum_add;
  logic [WEIGHT_W-1:0] rs_weight;
  logic                accept;
  logic                out_free;

  assign idx_inc   = idx_r + CNT_ONE;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign m_raddr = idx_r[AW-1:0];
  // close-up reads the entry after the slot being filled
  assign w_raddr = (state_r == S_SH_RD) ? idx_inc[AW-1:0] : idx_r[AW-1:0];

  assign rs_weight = (op_r == OP_RESTART) ? m_rdata.weight : WEIGHT_W'(1);
  assign sum_add   = {1'b0, sum_r} + (TOTAL_W + 1)'(rs_weight);

  always_comb begin
    state_nxt  = state_r;
    mcount_nxt = mcount_r;
    wcount_nxt = wcount_r;
    total_nxt  = total_r;
    sum_nxt    = sum_r;
    pick_nxt   = pick_r;
    idx_nxt    = idx_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    chosen_nxt = chosen_r;
    m_we       = 1'b0;
    m_waddr    = mcount_r[AW-1:0];
    m_wdata    = '{uses: in_limit, weight: in_weight, value: in_value};
    w_we       = 1'b0;
    w_waddr    = idx_r[AW-1:0];
    w_wdata    = w_rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_tuser);
          status_nxt = ST_OK;
          chosen_nxt = '0;
          idx_nxt    = '0;
          sum_nxt    = '0;
          pick_nxt   = in_draw;
          state_nxt  = S_FIN;
          case (in_tuser) inside
            OP_CLEAR: begin
              mcount_nxt = '0;
            end
            OP_APPEND: begin
              if (mcount_r >= CNT_MAX) begin
                status_nxt = ST_FULL;
              end else begin
                m_we       = 1'b1;
                mcount_nxt = mcount_r + CNT_ONE;
              end
            end
            OP_RESTART, OP_UNIFORM: begin
              if (mcount_r == '0) begin
                wcount_nxt = '0;
                total_nxt  = '0;
              end else begin
                state_nxt = S_RS_RD;
              end
            end
            OP_DRAW: begin
              if (mcount_r == '0) begin
                status_nxt = ST_DEFAULT;
              end else if (total_r == '0 || wcount_r == '0) begin
                status_nxt = ST_NONE;
              end else begin
                state_nxt = S_DR_RD;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RS_RD: begin
        state_nxt = S_RS_WR;
      end
      S_RS_WR: begin
        w_we    = 1'b1;
        w_wdata = '{uses:   (op_r == OP_RESTART) ? m_rdata.uses : '0,
                    weight: rs_weight,
                    value:  m_rdata.value};
        sum_nxt = sum_add[TOTAL_W] ? TOTAL_MAX : sum_add[TOTAL_W-1:0];
        idx_nxt = idx_inc;
        if (idx_inc == mcount_r) begin
          wcount_nxt = mcount_r;
          total_nxt  = sum_add[TOTAL_W] ? TOTAL_MAX : sum_add[TOTAL_W-1:0];
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_RS_RD;
        end
      end
      S_DR_RD: begin
        state_nxt = S_DR_CM;
      end
      S_DR_CM: begin
        if (pick_r < TOTAL_W'(w_rdata.weight)) begin
          chosen_nxt = w_rdata.value;
          state_nxt  = S_FIN;
          if (w_rdata.uses != '0) begin
            if (w_rdata.uses == LIMIT_W'(1)) begin
              // last use: remove entry and close up the rest
              total_nxt = (total_r > TOTAL_W'(w_rdata.weight)) ?
                          total_r - TOTAL_W'(w_rdata.weight) : '0;
              if (idx_inc < wcount_r) begin
                state_nxt = S_SH_RD;
              end else begin
                wcount_nxt = wcount_r - CNT_ONE;
              end
            end else begin
              w_we         = 1'b1;
              w_wdata.uses = w_rdata.uses - LIMIT_W'(1);
            end
          end
        end else begin
          pick_nxt = pick_r - TOTAL_W'(w_rdata.weight);
          idx_nxt  = idx_inc;
          if (idx_inc == wcount_r) begin
            status_nxt = ST_NONE;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_DR_RD;
          end
        end
      end
      S_SH_RD: begin
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        w_we    = 1'b1;
        idx_nxt = idx_inc;
        if ((idx_inc + CNT_ONE) == wcount_r) begin
          wcount_nxt = wcount_r - CNT_ONE;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcount_r    <= '0;
      wcount_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mcount_r <= mcount_nxt;
      wcount_r <= wcount_nxt;
      total_r  <= total_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    pick_r   <= pick_nxt;
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
    chosen_r <= chosen_nxt;
    if (state_r == S_FIN && out_free) begin
      out_status_r <= status_r;
      out_data_r   <= {5'b0, ENTRIES_W'(wcount_r), total_r, chosen_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_counts_range: assert property (@(posedge clk) disable iff (!rst_n)
    mcount_r <= CNT_MAX && wcount_r <= CNT_MAX) else $error("count overflow");
  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DR_CM || state_r == S_SH_RD) |-> idx_r < wcount_r)
    else $error("scan past working table");
  a_fin_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_free) |=> state_r == S_FIN)
    else $error("result dropped");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import wpl_pkg::*;

  localparam int MAXN = 16;
  localparam int CYCLE_LIMIT = 900000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  weighted_pick_with_use_limits_unit #(.MAX_ENTRIES(MAXN)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [2:0]          op;
    logic [VALUE_W-1:0]  val;
    logic [WEIGHT_W-1:0] wt;
    logic [LIMIT_W-1:0]  lim;
    logic [TOTAL_W-1:0]  pick;
  } request_t;

  typedef struct {
    logic [1:0]           status;
    logic [VALUE_W-1:0]   chosen;
    logic [TOTAL_W-1:0]   total;
    logic [ENTRIES_W-1:0] entries;
  } pick_result_t;

  // predictor copy of the tables
  logic [VALUE_W-1:0]  m_val[MAXN];
  logic [WEIGHT_W-1:0] m_wt[MAXN];
  logic [LIMIT_W-1:0]  m_lim[MAXN];
  int                  m_cnt;
  logic [VALUE_W-1:0]  w_val[MAXN];
  logic [WEIGHT_W-1:0] w_wt[MAXN];
  logic [LIMIT_W-1:0]  w_uses[MAXN];
  int                  w_cnt;
  longint              total;

  pick_result_t pending_picks[$];
  int errors = 0;
  int sent = 0, got = 0, draws_hit = 0;
  bit bp_active = 0;

  function automatic pick_result_t roulette_step(request_t r);
    pick_result_t res;
    longint rem, sum;
    bit hit;
    res = '{ST_OK, '0, '0, '0};
    case (r.op)
      OP_CLEAR: m_cnt = 0;
      OP_APPEND: begin
        if (m_cnt >= MAXN) res.status = ST_FULL;
        else begin
          m_val[m_cnt] = r.val;
          m_wt[m_cnt] = r.wt;
          m_lim[m_cnt] = r.lim;
          m_cnt++;
        end
      end
      OP_RESTART, OP_UNIFORM: begin
        sum = 0;
        for (int i = 0; i < m_cnt; i++) begin
          w_val[i] = m_val[i];
          w_wt[i] = (r.op == OP_RESTART) ? m_wt[i] : 16'd1;
          w_uses[i] = (r.op == OP_RESTART) ? m_lim[i] : 8'd0;
          sum += w_wt[i];
        end
        w_cnt = m_cnt;
        total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;
      end
      OP_DRAW: begin
        if (m_cnt == 0) res.status = ST_DEFAULT;
        else begin
          rem = r.pick;
          hit = 0;
          if (total > 0) begin
            for (int i = 0; i < w_cnt; i++) begin
              if (rem < w_wt[i]) begin
                hit = 1;
                res.chosen = w_val[i];
                if (w_uses[i] > 0) begin
                  w_uses[i]--;
                  if (w_uses[i] == 0) begin
                    total = (total > w_wt[i]) ? total - w_wt[i] : 0;
                    for (int j = i; j + 1 < w_cnt; j++) begin
                      w_val[j] = w_val[j+1];
                      w_wt[j] = w_wt[j+1];
                      w_uses[j] = w_uses[j+1];
                    end
                    w_cnt--;
                  end
                end
                break;
              end
              rem -= w_wt[i];
            end
          end
          if (!hit) res.status = ST_NONE;
        end
      end
      default: ;
    endcase
    res.total = total[TOTAL_W-1:0];
    res.entries = w_cnt[ENTRIES_W-1:0];
    return res;
  endfunction

  function automatic bit same_result(pick_result_t x, pick_result_t y);
    return x.status === y.status && x.chosen === y.chosen && x.total === y.total &&
           x.entries === y.entries;
  endfunction

  // idle with a chance of 11 in 100, except in a quiet window
  function automatic bit take_gap(int cyc);
    if (cyc > 3000 && cyc < 9000) return 0;
    return $urandom_range(99) < 11;
  endfunction

  int cycle = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("%0t timeout, %0d requests sent, %0d results", $time, sent, got);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off once traffic is running
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (bp_active) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 400) bp_active <= 0;
    end else if (hold_cnt == 0 && sent > 200) begin
      out_tready <= 1'b0;
      bp_active <= 1;
    end else out_tready <= !take_gap(cycle);
  end

  always @(posedge clk) begin
    pick_result_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      got++;
      a.status = out_tuser;
      a.chosen = out_tdata[9:0];
      a.total = out_tdata[29:10];
      a.entries = out_tdata[34:30];
      if (pending_picks.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $time, a);
      end else begin
        e = pending_picks.pop_front();
        if (a.status == ST_OK && a.chosen != 0) draws_hit++;
        if (!same_result(a, e) || out_tdata[39:35] !== '0) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, e, a);
        end
      end
    end
  end

  task automatic add_expected(pick_result_t x);
    pending_picks = {pending_picks, x};
  endtask

  // drive one request until in_tready, then queue its predicted result
  task automatic send(request_t r);
    pick_result_t exp_res;
    while (take_gap(cycle)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tdata <= {2'b0, r.pick, r.lim, r.wt, r.val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_res = roulette_step(r);
    add_expected(exp_res);
    sent++;
  endtask

  request_t directed[$];
  pick_result_t typed[$];

  task automatic add_row(request_t r);
    directed = {directed, r};
  endtask

  task automatic add_typed(pick_result_t x);
    typed = {typed, x};
  endtask

  function automatic request_t mk(int op, int v = 0, int w = 0, int l = 0, int p = 0);
    request_t r;
    r.op = 3'(op);
    r.val = VALUE_W'(v);
    r.wt = WEIGHT_W'(w);
    r.lim = LIMIT_W'(l);
    r.pick = TOTAL_W'(p);
    return r;
  endfunction

  task automatic random_session();
    int n;
    n = $urandom_range(1, 100) < 85 ? $urandom_range(1, 6) : $urandom_range(7, 17);
    send(mk(OP_CLEAR));
    for (int i = 0; i < n; i++)
      send(mk(OP_APPEND, $urandom_range(1023),
              $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(40),
              $urandom_range(2) == 0 ? 0 : $urandom_range(1, 4)));
    send(mk($urandom_range(4) == 0 ? OP_UNIFORM : OP_RESTART));
    for (int i = 0; i < $urandom_range(4, 14); i++) begin
      if ($urandom_range(9) == 0)
        send(mk($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom));
      else
        send(mk(OP_DRAW, 0, 0, 0,
                $urandom_range(7) == 0 ? $urandom_range(1048575)
                : $urandom_range(total > 0 ? int'(total) : 0)));
    end
  endtask

  initial begin
    pick_result_t e;
    m_cnt = 0; w_cnt = 0; total = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed expectations for the obvious rows
    add_row(mk(OP_DRAW, 0, 0, 0, 5));                       // empty master table
    add_typed('{ST_DEFAULT, '0, '0, '0});
    add_row(mk(OP_APPEND, 1023, 65535, 255));
    add_row(mk(OP_APPEND, 0, 0, 0));
    add_row(mk(OP_DRAW, 0, 0, 0, 0));                       // zero total
    add_typed('{ST_OK, '0, '0, '0});
    add_typed('{ST_OK, '0, '0, '0});
    add_typed('{ST_NONE, '0, '0, '0});
    for (int i = 0; i < 14; i++) add_row(mk(OP_APPEND, i, 65535, 1));
    add_row(mk(OP_APPEND, 7, 7, 7));                        // table full
    add_row(mk(OP_RESTART));                                // near-max total
    add_row(mk(OP_DRAW, 0, 0, 0, 0));
    add_row(mk(OP_DRAW, 0, 0, 0, 1048575));                 // past the end
    add_row(mk(OP_UNIFORM));
    add_row(mk(OP_DRAW, 0, 0, 0, 15));
    add_row(mk(7, 5, 5, 5, 5));                             // ignored op
    add_row(mk(OP_CLEAR));                                  // work table survives

    for (int i = 0; i < directed.size(); i++) begin
      send(directed[i]);
      if (i < typed.size()) begin
        e = pending_picks[$];
        if (!same_result(e, typed[i])) begin
          errors++;
          $display("%0t predictor row %0d: expected %p actual %p", $time, i, typed[i], e);
        end
      end
    end

    // extreme weights with small use limits
    send(mk(OP_APPEND, 3, 65535, 1));
    send(mk(OP_APPEND, 5, 1, 2));
    send(mk(OP_RESTART));
    for (int i = 0; i < 4; i++) send(mk(OP_DRAW, 0, 0, 0, 65535));

    for (int i = 0; i < 12; i++) random_session();
    while (sent < 1700) random_session();
    in_tvalid <= 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d requests, %0d results, %0d successful picks.", sent, got, draws_hit);
    if (errors == 0 && pending_picks.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
